// ===== hw/rtl/fisq_pkg.sv =====
// ---------------------------------------------------------------------------
// fisq_pkg
// Types, constants and binary32 arithmetic helpers for the fast inverse
// square root core. Each operation is split into a front and a back half.
// ---------------------------------------------------------------------------
package fisq_pkg;

  localparam int unsigned NumStages = 10;

  localparam logic [30:0] MagicReset   = 31'h5f3759df;
  localparam logic [31:0] CanonNan     = 32'h7fc00000;
  localparam logic [31:0] OneHalf      = 32'h3f000000;
  localparam logic [31:0] ThreeHalves  = 32'h3fc00000;

  // Multiplier front half: special result or raw significand product
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [10:0] e;
    logic [47:0]        p;
  } mul_pre_t;

  // Adder front half: special result or aligned sum
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        sign;
    logic [8:0]  e;
    logic [27:0] sum;
  } add_pre_t;

  // Unpack both operands, catch specials, form the 24x24 product
  function automatic mul_pre_t fp_mul_pre(input logic [31:0] a, input logic [31:0] b);
    mul_pre_t   r;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    r.sign      = a[31] ^ b[31];
    r.spec      = 1'b1;
    r.spec_bits = 32'd0;
    r.e         = 11'sd0;
    r.p         = 48'd0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      r.spec_bits = CanonNan;
    end else if (a_inf || b_inf) begin
      r.spec_bits = {r.sign, 8'hff, 23'd0};
    end else if (a_zero || b_zero) begin
      r.spec_bits = {r.sign, 31'd0};
    end else begin
      r.spec = 1'b0;
      r.e    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
      r.p    = 48'(ma) * 48'(mb);
    end
    return r;
  endfunction

  // Normalise, denormalise where needed and round to nearest even
  function automatic logic [31:0] fp_mul_post(input mul_pre_t m);
    logic [5:0]         lz;
    logic [47:0]        pn, shd;
    logic signed [10:0] eb;
    logic [10:0]        sh_full;
    logic [5:0]         sh;
    logic [30:0]        packed_v;
    logic               g, s, rnd;
    logic [31:0]        res;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (m.p[i]) lz = 6'(47 - i);
    end
    pn  = m.p << lz;
    eb  = m.e + 11'sd1 - $signed({5'b00000, lz});
    shd = 48'd0;
    sh_full = 11'd0;
    sh = 6'd0;
    if (m.spec) begin
      res = m.spec_bits;
    end else if (eb >= 11'sd255) begin
      res = {m.sign, 8'hff, 23'd0};
    end else begin
      if (eb >= 11'sd1) begin
        packed_v = {eb[7:0], pn[46:24]};
        g = pn[23];
        s = |pn[22:0];
      end else begin
        sh_full = 11'(11'sd1 - eb);
        sh  = (sh_full > 11'd48) ? 6'd48 : sh_full[5:0];
        shd = pn >> sh;
        packed_v = {8'd0, shd[46:24]};
        g = shd[23];
        s = (|shd[22:0]) | (|(pn & ((48'd1 << sh) - 48'd1)));
      end
      rnd = g & (s | packed_v[0]);
      res = {m.sign, packed_v + 31'(rnd)};
    end
    return res;
  endfunction

  // Order by magnitude, align the smaller operand, add or subtract
  function automatic add_pre_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
    add_pre_t    r;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] lg, sm;
    logic [7:0]  el, es, d;
    logic [26:0] xl, xs, al;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    swap  = b[30:0] > a[30:0];
    lg    = swap ? b : a;
    sm    = swap ? a : b;
    el    = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d     = el - es;
    xl    = {lg[30:23] != 8'd0, lg[22:0], 3'b000};
    xs    = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
    if (d >= 8'd27) begin
      al = {26'd0, |xs};
    end else begin
      al = (xs >> d) | 27'(|(xs & ((27'd1 << d) - 27'd1)));
    end
    r.spec      = 1'b1;
    r.spec_bits = 32'd0;
    r.sign      = lg[31];
    r.e         = {1'b0, el};
    r.sum       = (lg[31] ^ sm[31]) ? ({1'b0, xl} - {1'b0, al}) : ({1'b0, xl} + {1'b0, al});
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      r.spec_bits = CanonNan;
    end else if (a_inf) begin
      r.spec_bits = a;
    end else if (b_inf) begin
      r.spec_bits = b;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r.spec_bits = {a[31] & b[31], 31'd0};
    end else begin
      r.spec = 1'b0;
    end
    return r;
  endfunction

  // Normalise the sum, stop at the subnormal floor, round to nearest even
  function automatic logic [31:0] fp_add_post(input add_pre_t p);
    logic [4:0]  lz, sh;
    logic [8:0]  e, lim;
    logic [26:0] n;
    logic [23:0] mant;
    logic [30:0] packed_v;
    logic        rnd;
    logic [31:0] res;
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (p.sum[i]) lz = 5'(26 - i);
    end
    lim = p.e - 9'd1;
    sh  = (9'(lz) < lim) ? lz : lim[4:0];
    if (p.sum[27]) begin
      n = {p.sum[27:2], p.sum[1] | p.sum[0]};
      e = p.e + 9'd1;
    end else begin
      n = p.sum[26:0] << sh;
      e = p.e - 9'(sh);
    end
    mant     = n[26:3];
    packed_v = {mant[23] ? e[7:0] : 8'd0, mant[22:0]};
    rnd      = n[2] & ((|n[1:0]) | packed_v[0]);
    if (p.spec) begin
      res = p.spec_bits;
    end else if (p.sum == 28'd0) begin
      res = 32'd0;
    end else if (e >= 9'd255) begin
      res = {p.sign, 8'hff, 23'd0};
    end else begin
      res = {p.sign, packed_v + 31'(rnd)};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/fisq_in_if.sv =====
// ---------------------------------------------------------------------------
// fisq_in_if
// Input channel: one binary32 word per handshake.
// ---------------------------------------------------------------------------
interface fisq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;

  modport source (output valid, output x_bits, input ready);
  modport sink   (input valid, input x_bits, output ready);
endinterface

// ===== hw/rtl/fisq_out_if.sv =====
// ---------------------------------------------------------------------------
// fisq_out_if
// Output channel: one binary32 result word per handshake.
// ---------------------------------------------------------------------------
interface fisq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== hw/rtl/fast_inverse_sqrt_core.sv =====
// Throughput: one word per cycle; each stage holds only when the one after it is full and stalled.
// The ten stages are five binary32 operations, each a front half (unpack, align, multiply)
// and a back half (normalise, round).
// Reset: valid bits clear and the magic register returns to 0x5f3759df; data is not reset.
// ---------------------------------------------------------------------------
// fast_inverse_sqrt_core
// Approximate 1/sqrt(x): integer initial guess followed by one Newton step.
// ---------------------------------------------------------------------------
module fast_inverse_sqrt_core import fisq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          magic_we_i,
  input  logic [30:0]   magic_wdata_i,
  fisq_in_if.sink       in_i,
  fisq_out_if.source    out_o
);

  logic [30:0]          magic_q;
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  logic [31:0]          y_q [8];
  mul_pre_t             s1_mp_q, s3_mp_q, s5_mp_q, s9_mp_q;
  add_pre_t             s7_ap_q;
  logic [31:0]          s2_h_q, s4_hy_q, s6_t_q, s8_u_q, s10_r_q;
  logic [31:0]          guess;

  // Magic register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
    end else if (magic_we_i) begin
      magic_q <= magic_wdata_i;
    end
  end

  // Stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready        = en[0];
  assign out_o.valid       = v_q[NumStages-1];
  assign out_o.result_bits = s10_r_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Initial guess: magic minus arithmetically halved input bits
  assign guess = {1'b0, magic_q} - {in_i.x_bits[31], in_i.x_bits[31:1]};

  // Data path
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_mp_q <= fp_mul_pre(OneHalf, in_i.x_bits);
      y_q[0]  <= guess;
    end
    if (en[1]) begin
      s2_h_q <= fp_mul_post(s1_mp_q);
      y_q[1] <= y_q[0];
    end
    if (en[2]) begin
      s3_mp_q <= fp_mul_pre(s2_h_q, y_q[1]);
      y_q[2]  <= y_q[1];
    end
    if (en[3]) begin
      s4_hy_q <= fp_mul_post(s3_mp_q);
      y_q[3]  <= y_q[2];
    end
    if (en[4]) begin
      s5_mp_q <= fp_mul_pre(s4_hy_q, y_q[3]);
      y_q[4]  <= y_q[3];
    end
    if (en[5]) begin
      s6_t_q <= fp_mul_post(s5_mp_q);
      y_q[5] <= y_q[4];
    end
    if (en[6]) begin
      s7_ap_q <= fp_add_pre(ThreeHalves, {~s6_t_q[31], s6_t_q[30:0]});
      y_q[6]  <= y_q[5];
    end
    if (en[7]) begin
      s8_u_q <= fp_add_post(s7_ap_q);
      y_q[7] <= y_q[6];
    end
    if (en[8]) begin
      s9_mp_q <= fp_mul_pre(y_q[7], s8_u_q);
    end
    if (en[9]) begin
      s10_r_q <= fp_mul_post(s9_mp_q);
    end
  end

  // Checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted word did not enter the first stage");

  a_nan_canonical: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.result_bits[30:23] == 8'hff) && (out_o.result_bits[22:0] != 23'd0)
    |-> out_o.result_bits == CanonNan)
    else $error("non-canonical NaN on output");

  a_magic_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    magic_we_i |=> magic_q == $past(magic_wdata_i))
    else $error("magic register write lost");

endmodule
